// ----- src/jbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbf_pkg - shared types and constants of the jitter buffer
// Word layouts, status codes and the default sizes of the playout store.
// ----------------------------------------------------------------------------
package jbf_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_BITS     = 32;
   localparam int LEVEL_BITS    = 7;
   localparam int STATUS_BITS   = 3;

   localparam logic [LEVEL_BITS-1:0] THR_RESET = 7'd50;

   localparam logic KIND_ADD     = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ADDED     = 3'd0,
      ST_DROPPED   = 3'd1,
      ST_DELIVERED = 3'd2,
      ST_BUFFERING = 3'd3,
      ST_RAN_EMPTY = 3'd4
   } jbf_status_type;

   typedef struct packed {
      logic                 kind;
      logic [WORD_BITS-1:0] packet_word;
   } jbf_req_type;

   typedef struct packed {
      jbf_status_type        status;
      logic [WORD_BITS-1:0]  packet_out;
      logic [LEVEL_BITS-1:0] fill_level;
      logic                  is_buffering;
   } jbf_rsp_type;

   // store operation chosen by the controller for one accepted word
   typedef struct packed {
      logic push;
      logic pop;
   } jbf_op_type;

   // controller decision, captured in the result register
   typedef struct packed {
      jbf_status_type        status;
      logic [LEVEL_BITS-1:0] fill_level;
      logic                  is_buffering;
   } jbf_decision_type;

endpackage : jbf_pkg
`default_nettype wire

// ----- src/jbf_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbf_store - packet word ring store
// Circular memory with head and tail pointers and a registered read port.
// ----------------------------------------------------------------------------
module jbf_store
   import jbf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire jbf_op_type           op,
   input  wire logic [WORD_BITS-1:0] push_word,
   output logic      [WORD_BITS-1:0] pop_word
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_ff;
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [PTR_BITS-1:0]  tail_ff, tail_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (op.pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      end
      if (op.push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // a word written at one edge is readable at the next
   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[tail_ff] <= push_word;
      end
      if (op.pop) begin
         rd_ff <= mem[head_ff];
      end
   end

   assign pop_word = rd_ff;

endmodule : jbf_store
`default_nettype wire

// ----- src/jbf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jbf_ctrl - playout controller
// Holds the fill count and buffering mode and picks each word's outcome.
// ----------------------------------------------------------------------------
module jbf_ctrl
   import jbf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  kind,
   input  wire logic [LEVEL_BITS-1:0] threshold,
   output jbf_op_type                 op,
   output jbf_decision_type           decision
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = (CNT_BITS > LEVEL_BITS) ? CNT_BITS : LEVEL_BITS;
   localparam logic [CNT_BITS-1:0] CNT_FULL  = CNT_BITS'(DEPTH);
   localparam logic [CMP_BITS-1:0] CMP_DEPTH = CMP_BITS'(DEPTH);
   localparam logic [CMP_BITS-1:0] CMP_ONE   = CMP_BITS'(1);

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                buffering_ff, buffering_in;
   logic [CMP_BITS-1:0] thr_eff;
   logic [CMP_BITS-1:0] count_wide;
   jbf_status_type      status;

   // threshold clamped into 1 .. DEPTH
   always_comb begin
      thr_eff = CMP_BITS'(threshold);
      if (threshold == '0) begin
         thr_eff = CMP_ONE;
      end else if (thr_eff > CMP_DEPTH) begin
         thr_eff = CMP_DEPTH;
      end
   end

   assign count_wide = CMP_BITS'(count_ff);

   always_comb begin
      op           = '0;
      buffering_in = buffering_ff;
      status       = ST_ADDED;
      if (kind == KIND_ADD) begin
         if (count_ff == CNT_FULL) begin
            status = ST_DROPPED;
         end else begin
            op.push = 1'b1;
         end
      end else if (buffering_ff) begin
         if (count_wide >= thr_eff) begin
            buffering_in = 1'b0;
            op.pop       = 1'b1;
            status       = ST_DELIVERED;
         end else begin
            status = ST_BUFFERING;
         end
      end else if (count_ff == '0) begin
         buffering_in = 1'b1;
         status       = ST_RAN_EMPTY;
      end else begin
         op.pop = 1'b1;
         status = ST_DELIVERED;
      end
      if (!accept) begin
         op           = '0;
         buffering_in = buffering_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (op.push) begin
         count_in = count_ff + 1'b1;
      end else if (op.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         buffering_ff <= 1'b1;
      end else begin
         count_ff     <= count_in;
         buffering_ff <= buffering_in;
      end
   end

   assign decision.status       = status;
   assign decision.fill_level   = LEVEL_BITS'(count_in);
   assign decision.is_buffering = buffering_in;

endmodule : jbf_ctrl
`default_nettype wire

// ----- src/jitter_buffer_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each accepted req word has its rsp word registered on the edge that accepts it.
// Throughput: 1 word per cycle unless rsp stalls; each step is one controller
//   decision plus at most one store push or pop, all before the rsp register.
// Reset (synchronous, active high): store empty, buffering mode on,
//   start threshold 50, no rsp word pending. Store contents are not cleared.
// ----------------------------------------------------------------------------
// jitter_buffer_fifo - playout jitter buffer
// FIFO of packet words that holds back playout until a start threshold.
// ----------------------------------------------------------------------------
module jitter_buffer_fifo
   import jbf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire jbf_req_type           req_data,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output jbf_rsp_type                rsp_data,
   // start threshold register
   input  wire logic                  csr_wen,
   input  wire logic [LEVEL_BITS-1:0] csr_wdata
);

   logic                  accept;
   logic [LEVEL_BITS-1:0] thr_ff;
   jbf_op_type            op;
   jbf_decision_type      decision;
   jbf_decision_type      result_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]  pop_word;

   // Raw threshold is kept; the controller clamps it when comparing.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   // The rsp register frees up in the same cycle it is taken, so a new
   // word can enter every cycle while the consumer keeps up.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   jbf_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .kind     (req_data.kind),
      .threshold(thr_ff),
      .op       (op),
      .decision (decision)
   );

   // pop data lands in the store's read register on the same edge as the
   // decision lands in result_ff, so the two stay aligned
   jbf_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .push_word(req_data.packet_word),
      .pop_word (pop_word)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= decision;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.status        = result_ff.status;
   assign rsp_data.fill_level    = result_ff.fill_level;
   assign rsp_data.is_buffering  = result_ff.is_buffering;
   // packet_out reads zero unless a word was delivered
   assign rsp_data.packet_out    = (result_ff.status == ST_DELIVERED) ? pop_word : '0;

endmodule : jitter_buffer_fifo
`default_nettype wire
